// ===== design/sha1_pkg.sv =====
`timescale 1ns / 1ps

package sha1_pkg;

  typedef logic [31:0]       word_t;
  typedef logic [15:0][31:0] block_t;
  typedef logic [4:0][31:0]  chain_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DATA_COMP,
    ST_PAD,
    ST_PAD_COMP,
    ST_LEN,
    ST_FIN_COMP,
    ST_OUT
  } sha1_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } sha1_core_stat_t;

  localparam chain_t INIT_CHAIN = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam int unsigned ROT_B     = 30;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] MAX_BYTES  = 3'd4;
  localparam logic [2:0] LAST_INDEX = 3'd4;

  function automatic word_t round_k(input logic [6:0] round);
    word_t k;
    if (round < 7'd20) begin
      k = 32'h5A827999;
    end else if (round < 7'd40) begin
      k = 32'h6ED9EBA1;
    end else if (round < 7'd60) begin
      k = 32'h8F1BBCDC;
    end else begin
      k = 32'hCA62C1D6;
    end
    return k;
  endfunction

endpackage

// ===== design/sha1_if.sv =====
`timescale 1ns / 1ps

interface sha1_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic [2:0]  valid_bytes;
  logic        message_end;

  modport source (output valid, output data_word, output valid_bytes,
                  output message_end, input ready);
  modport sink   (input valid, input data_word, input valid_bytes,
                  input message_end, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index,
                  output last_word, input ready);
  modport sink   (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

// ===== design/sha1_core.sv =====
`timescale 1ns / 1ps

module sha1_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  sha1_pkg::block_t          block_i,
  input  sha1_pkg::chain_t          chain_i,
  output sha1_pkg::chain_t          state_o,
  output sha1_pkg::sha1_core_stat_t stat_o
);
  import sha1_pkg::*;

  logic       busy_q, busy_d;
  logic       done_q, done_d;
  logic [6:0] round_q, round_d;

  word_t  a_q, b_q, c_q, d_q, e_q;
  word_t  f, t, w_new;
  block_t w_q;

  // round function selection
  always_comb begin
    if (round_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
    end else if (round_q >= 7'd40 && round_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
    end else begin
      f = b_q ^ c_q ^ d_q;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + w_q[0] + round_k(round_q);
    w_new = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  always_comb begin
    busy_d  = busy_q;
    round_d = round_q;
    done_d  = busy_q && (round_q == LAST_ROUND);
    if (start_i) begin
      busy_d  = 1'b1;
      round_d = '0;
    end else if (busy_q) begin
      round_d = round_q + 7'd1;
      if (round_q == LAST_ROUND) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      round_q <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      round_q <= round_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      w_q <= block_i;
      a_q <= chain_i[0];
      b_q <= chain_i[1];
      c_q <= chain_i[2];
      d_q <= chain_i[3];
      e_q <= chain_i[4];
    end else if (busy_q) begin
      // message schedule as a sixteen word shift line
      for (int j = 0; j < 15; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[15] <= w_new;
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[31-ROT_B:0], b_q[31:32-ROT_B]};
      b_q <= a_q;
      a_q <= t;
    end
  end

  assign state_o     = {e_q, d_q, c_q, b_q, a_q};
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

endmodule

// ===== design/sha1_hash_engine.sv =====
`timescale 1ns / 1ps
// channel   dir  payload                                  transfer
// in_chan   in   data_word, valid_bytes, message_end      valid & ready
// out_chan  out  digest_word, word_index, last_word       valid & ready
//
// a word that leaves its block unfilled and does not end the message keeps in_chan ready
// a word that fills a block starts the shared round unit, one round per cycle, and stalls in_chan until it is done
// on full words the input stalls once per block of sixteen; message end adds one or two
// blocks through the round unit plus five output transfers
// reset is asynchronous and active low; it loads the initial chaining words
// in_chan is held not ready while the round unit runs and at message end until the digest
// is taken

module sha1_hash_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  sha1_in_if.sink         in_chan_i,
  sha1_out_if.source      out_chan_o
);
  import sha1_pkg::*;

  sha1_state_e state_q, state_d;

  chain_t      chain_q, chain_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic        end_q, end_d;
  logic [2:0]  cnt_q, cnt_d;
  block_t      buf_q, buf_d, blk_next;

  chain_t          core_state;
  sha1_core_stat_t core_stat;

  logic        acc, out_xfer, start, in_ready, out_valid;
  logic [2:0]  n_bytes;
  logic [3:0]  idx;
  logic [1:0]  ofs;
  logic [6:0]  fill_sum;
  logic        spill, fits;
  logic [63:0] win;
  word_t       keep_old, keep_new, merged, pad_word;

  assign idx      = fill_q[5:2];
  assign ofs      = fill_q[1:0];
  assign acc      = in_chan_i.valid && in_ready;
  assign out_xfer = out_valid && out_chan_o.ready;
  assign n_bytes  = (in_chan_i.valid_bytes > MAX_BYTES) ? MAX_BYTES : in_chan_i.valid_bytes;
  assign fill_sum = 7'(fill_q) + 7'(n_bytes);
  assign spill    = (3'(ofs) + n_bytes) > MAX_BYTES;
  assign fits     = fill_q < LEN_OFFSET;

  // byte packing window over the current word and the next
  always_comb begin
    keep_new = ~(32'hFFFF_FFFF >> {n_bytes, 3'b000});
    keep_old = ~(32'hFFFF_FFFF >> {ofs, 3'b000});
    win      = {in_chan_i.data_word & keep_new, 32'h0} >> {ofs, 3'b000};
    merged   = (buf_q[idx] & keep_old) | win[63:32];
    pad_word = (buf_q[idx] & keep_old) | ({PAD_MARK, 24'h0} >> {ofs, 3'b000});
  end

  always_comb begin
    blk_next = buf_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          blk_next[idx] = merged;
          if (spill && idx != 4'd15) begin
            blk_next[idx + 4'd1] = win[31:0];
          end
        end
      end
      ST_PAD: begin
        for (int j = 0; j < 16; j++) begin
          if (4'(j) > idx) begin
            blk_next[j] = '0;
          end
        end
        blk_next[idx] = pad_word;
        if (fits) begin
          blk_next[14] = len_q[63:32];
          blk_next[15] = len_q[31:0];
        end
      end
      ST_LEN: begin
        blk_next     = '0;
        blk_next[14] = len_q[63:32];
        blk_next[15] = len_q[31:0];
      end
      default: begin
        blk_next = buf_q;
      end
    endcase
    buf_d = blk_next;
    if (state_q == ST_IDLE && acc && spill && idx == 4'd15) begin
      buf_d[0] = win[31:0];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (fill_sum[6]) begin
            state_d = ST_DATA_COMP;
          end else if (in_chan_i.message_end) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_DATA_COMP: begin
        if (core_stat.done) begin
          state_d = end_q ? ST_PAD : ST_IDLE;
        end
      end
      ST_PAD:      state_d = fits ? ST_FIN_COMP : ST_PAD_COMP;
      ST_PAD_COMP: begin
        if (core_stat.done) begin
          state_d = ST_LEN;
        end
      end
      ST_LEN:      state_d = ST_FIN_COMP;
      ST_FIN_COMP: begin
        if (core_stat.done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_xfer && cnt_q == LAST_INDEX) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    start     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        start    = acc && fill_sum[6];
      end
      ST_PAD:  start = 1'b1;
      ST_LEN:  start = 1'b1;
      ST_OUT:  out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        start     = 1'b0;
      end
    endcase
  end

  // datapath state
  always_comb begin
    chain_d = chain_q;
    fill_d  = fill_q;
    len_d   = len_q;
    end_d   = end_q;
    cnt_d   = cnt_q;
    if (acc) begin
      fill_d = fill_sum[5:0];
      len_d  = len_q + {58'h0, n_bytes, 3'b000};
      end_d  = in_chan_i.message_end;
    end
    if (core_stat.done) begin
      for (int j = 0; j < 5; j++) begin
        chain_d[j] = chain_q[j] + core_state[j];
      end
    end
    if (out_xfer) begin
      cnt_d = cnt_q + 3'd1;
      if (cnt_q == LAST_INDEX) begin
        chain_d = INIT_CHAIN;
        fill_d  = '0;
        len_d   = '0;
        end_d   = 1'b0;
        cnt_d   = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      chain_q <= INIT_CHAIN;
      fill_q  <= '0;
      len_q   <= '0;
      end_q   <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      chain_q <= chain_d;
      fill_q  <= fill_d;
      len_q   <= len_d;
      end_q   <= end_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  sha1_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .block_i (blk_next),
    .chain_i (chain_q),
    .state_o (core_state),
    .stat_o  (core_stat)
  );

  assign in_chan_i.ready        = in_ready;
  assign out_chan_o.valid       = out_valid;
  assign out_chan_o.digest_word = chain_q[cnt_q];
  assign out_chan_o.word_index  = cnt_q;
  assign out_chan_o.last_word   = (cnt_q == LAST_INDEX);

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |-> !core_stat.busy)
    else $error("round unit started while busy");

  a_out_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !core_stat.busy && !in_ready)
    else $error("digest offered while block still in work");

  a_short_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !in_chan_i.message_end && !fill_sum[6] |=> in_ready)
    else $error("word inside a block stalled the input");

  a_clean_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_xfer && out_chan_o.last_word |=> fill_q == '0 && len_q == '0 && chain_q == INIT_CHAIN)
    else $error("state not restored after digest");

endmodule
